/* rtl/brn_pkg.sv */
// Shared types, constants and helper functions for the bilinear resize and normalize block.
// Used by brn_front, brn_fifo, brn_back and bilinear_resize_normalize.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brn_pkg;

	// Output grid and fixed-point layout
	localparam int OUT_SIDE = 224;
	localparam int WFB      = 12;          // fractional bits of coordinates and weights
	localparam int OIW      = 8;           // output index width
	localparam int SZW      = 14;          // internal size width (holds up to 16383)
	localparam int CFGW     = 13;          // configuration data width
	localparam int QW       = 26;          // coordinate tracker width
	localparam int CNTW     = 4;           // per-axis match count width
	localparam int MIN_SRC_SIDE = 64;

	// Register indexes
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFGW-1:0] SIZE_RESET = 13'd224;

	// Normalization: n = floor(((v + NORM_BIAS) >> 9) / 255), out = n - HALF_SCALE
	localparam logic [32:0] NORM_BIAS  = 33'd65280;
	localparam logic [47:0] NORM_RECIP = 48'd8421505;   // ceil(2^31 / 255)
	localparam logic [15:0] HALF_SCALE = 16'd16384;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0]         out_x;
		logic [7:0]         out_y;
		logic signed [15:0] red_norm;
		logic signed [15:0] green_norm;
		logic signed [15:0] blue_norm;
		logic               last;
	} result_t;

	// Source coordinate tracker: output index, scaled coordinate and remainder mod 7
	typedef struct packed {
		logic [OIW-1:0] idx;
		logic [QW-1:0]  q;
		logic [2:0]     rem;
	} axis_t;

	// Per-axis constants derived from the effective source size
	typedef struct packed {
		logic [SZW-1:0] size;
		logic [QW-1:0]  qs;
		logic [2:0]     rs;
		logic [QW-1:0]  q0;
		logic [2:0]     r0;
	} axis_cfg_t;

	// One accepted pixel with its neighbors and the output ranges it completes
	typedef struct packed {
		pixel_t          pix;
		pixel_t          left;
		pixel_t          above;
		pixel_t          above_left;
		axis_t           xs;
		axis_t           ys;
		logic [CNTW-1:0] xcnt;
		logic [CNTW-1:0] ycnt;
	} desc_t;

	// Divide a size-range value by 7 with a reciprocal multiply
	function automatic logic [SZW-1:0] div7(input logic [SZW-1:0] v);
		logic [27:0] p;
		p = 28'(v) * 28'd9363;
		return SZW'(p[27:16]);
	endfunction

	// floor(128 * b / 7) for a residue b of 0 to 6
	function automatic logic [6:0] frac128(input logic [2:0] b);
		logic [6:0] r;
		case (b)
			3'd0: r = 7'd0;
			3'd1: r = 7'd18;
			3'd2: r = 7'd36;
			3'd3: r = 7'd54;
			3'd4: r = 7'd73;
			3'd5: r = 7'd91;
			3'd6: r = 7'd109;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	// Build the tracker start point and step for one axis
	function automatic axis_cfg_t make_axis_cfg(input logic [SZW-1:0] size);
		axis_cfg_t      c;
		logic [SZW-1:0] a;
		logic [SZW-1:0] b;
		logic [SZW-1:0] s2;
		logic [SZW-1:0] a2;
		logic [SZW-1:0] b2;
		logic [3:0]     b2x;
		a   = div7(size);
		b   = size - SZW'(a * SZW'(7));
		s2  = size + SZW'(OUT_SIDE);
		a2  = div7(s2);
		b2  = s2 - SZW'(a2 * SZW'(7));
		b2x = {b[2:0], 1'b0};
		c.size = size;
		c.qs   = (QW'(a) << 7) + QW'(frac128(b[2:0]));
		c.rs   = (b2x >= 4'd7) ? 3'(b2x - 4'd7) : b2x[2:0];
		c.q0   = (QW'(a2) << 6) + QW'(b2) * QW'(9);
		c.r0   = b2[2:0];
		return c;
	endfunction

	// Tracker start for output index zero
	function automatic axis_t axis_init(input axis_cfg_t c);
		axis_t t;
		t.idx = '0;
		t.q   = c.q0;
		t.rem = c.r0;
		return t;
	endfunction

	// Advance the tracker to the next output index
	function automatic axis_t axis_adv(input axis_t t, input axis_cfg_t c);
		axis_t      n;
		logic [3:0] rr;
		rr    = 4'(t.rem) + 4'(c.rs);
		n.idx = t.idx + OIW'(1);
		if (rr >= 4'd7) begin
			n.rem = 3'(rr - 4'd7);
			n.q   = t.q + c.qs + QW'(1);
		end else begin
			n.rem = rr[2:0];
			n.q   = t.q + c.qs;
		end
		return n;
	endfunction

	// Clamped upper neighbor of a tracked coordinate
	function automatic logic [SZW-1:0] hi_of(input logic [QW-1:0] q, input logic [SZW-1:0] size);
		logic [SZW-1:0] a;
		logic [SZW-1:0] top;
		a   = SZW'(q[QW-1:WFB]);
		top = size - SZW'(1);
		return (a > top) ? top : a;
	endfunction

	// True when the two neighbors along this axis are different source samples
	function automatic logic split_of(input logic [QW-1:0] q, input logic [SZW-1:0] size);
		logic [SZW-1:0] a;
		a = SZW'(q[QW-1:WFB]);
		return (a != '0) && (a <= size - SZW'(1));
	endfunction

endpackage
`default_nettype wire

/* rtl/bilinear_resize_normalize.sv */
// Bilinear resize to 224 by 224 with per-channel normalization to Q1.14.
// Source pixels enter in raster order on in_valid/in_stall; a pixel is taken when
// in_valid is high and in_stall is low. Each taken pixel completes zero or more output
// pixels, which leave on out_valid/out_stall with their coordinates; the last one
// caused by a pixel carries last set. Results follow the source scan, not raster order.
// Frame size is set through cfg_write/cfg_index/cfg_data; a size write made while the
// front is idle restarts the frame. The front takes a pixel, then steps through the
// matching output columns; the first pixel of a source row first steps through the
// matching output rows. in_stall stays high until the front is done with the pixel.
// The back emits one result per cycle while it holds a descriptor and out_stall does not
// hold it; each result passes the stage registers after the walker reaches it. A four-entry queue lets the
// front keep taking pixels while the back drains a burst. When the receiver holds
// out_stall, the back pipeline freezes, the queue fills, and then in_stall rises.
// Reset returns the frame position to the start and the sizes to 224; the row store
// keeps no reset value and needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_resize_normalize #(
	parameter int MAX_SRC_SIDE = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire brn_pkg::pixel_t       in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output brn_pkg::result_t           out_data,
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [brn_pkg::CFGW-1:0] cfg_data
);
	import brn_pkg::*;

	logic [CFGW-1:0] width_q, height_q;
	logic [SZW-1:0]  w_eff, h_eff;
	axis_cfg_t       xcfg, ycfg;
	logic            restart;
	logic            push, full, pop, empty;
	desc_t           push_data, pop_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_SRC_WIDTH)  width_q  <= cfg_data;
			if (cfg_index == REG_SRC_HEIGHT) height_q <= cfg_data;
		end
	end

	assign restart = cfg_write && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT);

	// Clamp sizes and derive tracker constants
	always_comb begin
		if (SZW'(width_q) < SZW'(MIN_SRC_SIDE))      w_eff = SZW'(MIN_SRC_SIDE);
		else if (SZW'(width_q) > SZW'(MAX_SRC_SIDE)) w_eff = SZW'(MAX_SRC_SIDE);
		else                                         w_eff = SZW'(width_q);
		if (SZW'(height_q) < SZW'(MIN_SRC_SIDE))      h_eff = SZW'(MIN_SRC_SIDE);
		else if (SZW'(height_q) > SZW'(MAX_SRC_SIDE)) h_eff = SZW'(MAX_SRC_SIDE);
		else                                          h_eff = SZW'(height_q);
		xcfg = make_axis_cfg(w_eff);
		ycfg = make_axis_cfg(h_eff);
	end

	brn_front #(
		.MAX_SRC_SIDE(MAX_SRC_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.restart   (restart),
		.xcfg      (xcfg),
		.ycfg      (ycfg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	brn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	brn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.xcfg      (xcfg),
		.ycfg      (ycfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* rtl/brn_fifo.sv */
// Short descriptor queue between the front and back parts.
// Depends on brn_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none
module brn_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire brn_pkg::desc_t push_data,
	output logic               full,
	input  wire logic          pop,
	output brn_pkg::desc_t     pop_data,
	output logic               empty
);
	import brn_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	desc_t        slot_q [DEPTH];
	logic [AW:0]  wr_q;
	logic [AW:0]  rd_q;

	assign empty    = (wr_q == rd_q);
	assign full     = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign pop_data = slot_q[rd_q[AW-1:0]];

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + (AW+1)'(1);
			if (pop && !empty) rd_q <= rd_q + (AW+1)'(1);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wr_q[AW-1:0]] <= push_data;
	end

endmodule
`default_nettype wire

/* rtl/brn_front.sv */
// Front part: accepts source pixels, keeps the row store and neighbors, finds output ranges.
// Depends on brn_pkg; feeds descriptors into brn_fifo.
`timescale 1ns / 1ps
`default_nettype none
module brn_front #(
	parameter int MAX_SRC_SIDE = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire brn_pkg::pixel_t    in_data,
	input  wire logic               restart,
	input  wire brn_pkg::axis_cfg_t xcfg,
	input  wire brn_pkg::axis_cfg_t ycfg,
	output logic                    push,
	output brn_pkg::desc_t          push_data,
	input  wire logic               full
);
	import brn_pkg::*;

	localparam int CW = $clog2(MAX_SRC_SIDE);

	typedef enum logic [2:0] {
		F_IDLE  = 3'b001,
		F_YSCAN = 3'b010,
		F_XSCAN = 3'b100
	} fstate_t;

	fstate_t         state_q;
	logic [CW-1:0]   col_q, row_q;
	logic [CW-1:0]   cur_c_q, cur_r_q;
	pixel_t          pix_q, left_q, left_snap_q, al_q, al_snap_q, rd_q;
	pixel_t          mem [MAX_SRC_SIDE];
	axis_t           xtrk_q, ytrk_q, xs_q, ys_q;
	logic [CNTW-1:0] xcnt_q, ycnt_q;

	logic acc, col_wrap, row_wrap, xhit, yhit, xdone, nores, finish;

	assign acc      = in_valid && (state_q == F_IDLE);
	assign in_stall = (state_q != F_IDLE);
	assign col_wrap = (SZW'(col_q) + SZW'(1)) >= xcfg.size;
	assign row_wrap = (SZW'(row_q) + SZW'(1)) >= ycfg.size;
	assign xhit     = (xtrk_q.idx < OIW'(OUT_SIDE)) &&
	                  (hi_of(xtrk_q.q, xcfg.size) == SZW'(cur_c_q));
	assign yhit     = (ytrk_q.idx < OIW'(OUT_SIDE)) &&
	                  (hi_of(ytrk_q.q, ycfg.size) == SZW'(cur_r_q));
	assign xdone    = (state_q == F_XSCAN) && !xhit;
	assign nores    = (xcnt_q == '0) || (ycnt_q == '0);
	assign push     = xdone && !nores && !full;
	assign finish   = xdone && (nores || !full);

	// Assemble the descriptor
	always_comb begin
		push_data.pix        = pix_q;
		push_data.left       = left_snap_q;
		push_data.above      = rd_q;
		push_data.above_left = al_snap_q;
		push_data.xs         = xs_q;
		push_data.ys         = ys_q;
		push_data.xcnt       = xcnt_q;
		push_data.ycnt       = ycnt_q;
	end

	// Row store: read the pixel above, then overwrite it with the new one
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q       <= mem[col_q];
			mem[col_q] <= in_data;
		end
	end

	// Sequence control, frame position and neighbor pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			left_q  <= '0;
			al_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (restart) begin
						col_q <= '0;
						row_q <= '0;
					end else if (acc) begin
						left_q  <= in_data;
						state_q <= (col_q == '0) ? F_YSCAN : F_XSCAN;
						if (col_wrap) begin
							col_q <= '0;
							row_q <= row_wrap ? '0 : row_q + CW'(1);
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				F_YSCAN: begin
					if (!yhit) state_q <= F_XSCAN;
				end
				F_XSCAN: begin
					if (finish) begin
						al_q    <= rd_q;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Capture the item and scan output ranges
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_q       <= in_data;
			left_snap_q <= left_q;
			al_snap_q   <= al_q;
			cur_c_q     <= col_q;
			cur_r_q     <= row_q;
			xcnt_q      <= '0;
			if (col_q == '0) begin
				xtrk_q <= axis_init(xcfg);
				xs_q   <= axis_init(xcfg);
				ycnt_q <= '0;
				if (row_q == '0) begin
					ytrk_q <= axis_init(ycfg);
					ys_q   <= axis_init(ycfg);
				end else begin
					ys_q   <= ytrk_q;
				end
			end else begin
				xs_q <= xtrk_q;
			end
		end
		if (state_q == F_YSCAN && yhit) begin
			ytrk_q <= axis_adv(ytrk_q, ycfg);
			ycnt_q <= ycnt_q + CNTW'(1);
		end
		if (state_q == F_XSCAN && xhit) begin
			xtrk_q <= axis_adv(xtrk_q, xcfg);
			xcnt_q <= xcnt_q + CNTW'(1);
		end
	end

endmodule
`default_nettype wire

/* rtl/brn_back.sv */
// Back part: walks each descriptor's output grid, interpolates and normalizes.
// Depends on brn_pkg; drains brn_fifo and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
module brn_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               empty,
	output logic                    pop,
	input  wire brn_pkg::desc_t     pop_data,
	input  wire brn_pkg::axis_cfg_t xcfg,
	input  wire brn_pkg::axis_cfg_t ycfg,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output brn_pkg::result_t        out_data
);
	import brn_pkg::*;

	localparam int WW = WFB + 1;
	localparam int TW = 21;
	localparam int VW = 32;
	localparam int PW = 48;

	function automatic logic [7:0] chan(input pixel_t p, input int k);
		logic [7:0] r;
		case (k)
			0:       r = p.red;
			1:       r = p.green;
			default: r = p.blue;
		endcase
		return r;
	endfunction

	logic en;
	// Grid walker
	logic            busy_q;
	desc_t           ent_q;
	axis_t           cx_q, cy_q;
	logic [CNTW-1:0] xrem_q, yrem_q;
	// Stage registers
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	pixel_t          tl_s1, tr_s1, bl_s1, br_s1;
	logic [WW-1:0]   wx_s1, iwx_s1, wy_s1, iwy_s1;
	logic [WW-1:0]   wy_s2, iwy_s2;
	logic [OIW-1:0]  x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic            last_s1, last_s2, last_s3, last_s4;
	logic [2:0][TW-1:0] top_s2, bot_s2;
	logic [2:0][VW-1:0] v_s3_d;
	logic [2:0][PW-1:0] prod_s4;
	result_t         res_s5;

	logic   dx, dy, last_c;
	pixel_t bl_c, tr_c, tl_c;

	assign en        = !v_s5 || !out_stall;
	assign pop       = en && !busy_q && !empty;
	assign out_valid = v_s5;
	assign out_data  = res_s5;

	// Pick the four neighbors for the current output position
	always_comb begin
		dx     = split_of(cx_q.q, xcfg.size);
		dy     = split_of(cy_q.q, ycfg.size);
		last_c = (xrem_q == CNTW'(1)) && (yrem_q == CNTW'(1));
		bl_c   = dx ? ent_q.left : ent_q.pix;
		tr_c   = dy ? ent_q.above : ent_q.pix;
		tl_c   = dy ? (dx ? ent_q.above_left : ent_q.above) : bl_c;
	end

	// Walk rows then columns of the descriptor's output range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (en) begin
			if (busy_q) begin
				if (last_c) busy_q <= 1'b0;
			end else if (!empty) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (busy_q) begin
				if (xrem_q != CNTW'(1)) begin
					cx_q   <= axis_adv(cx_q, xcfg);
					xrem_q <= xrem_q - CNTW'(1);
				end else if (yrem_q != CNTW'(1)) begin
					cy_q   <= axis_adv(cy_q, ycfg);
					cx_q   <= ent_q.xs;
					xrem_q <= ent_q.xcnt;
					yrem_q <= yrem_q - CNTW'(1);
				end
			end else if (!empty) begin
				ent_q  <= pop_data;
				cx_q   <= pop_data.xs;
				cy_q   <= pop_data.ys;
				xrem_q <= pop_data.xcnt;
				yrem_q <= pop_data.ycnt;
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Datapath: neighbors, horizontal blend, vertical blend, scale, normalize
	always_ff @(posedge clk) begin
		if (en) begin
			tl_s1   <= tl_c;
			tr_s1   <= tr_c;
			bl_s1   <= bl_c;
			br_s1   <= ent_q.pix;
			wx_s1   <= WW'(cx_q.q[WFB-1:0]);
			iwx_s1  <= (WW'(1) << WFB) - WW'(cx_q.q[WFB-1:0]);
			wy_s1   <= WW'(cy_q.q[WFB-1:0]);
			iwy_s1  <= (WW'(1) << WFB) - WW'(cy_q.q[WFB-1:0]);
			x_s1    <= cx_q.idx;
			y_s1    <= cy_q.idx;
			last_s1 <= last_c;

			for (int k = 0; k < 3; k++) begin
				top_s2[k] <= TW'(chan(tl_s1, k)) * TW'(iwx_s1) + TW'(chan(tr_s1, k)) * TW'(wx_s1);
				bot_s2[k] <= TW'(chan(bl_s1, k)) * TW'(iwx_s1) + TW'(chan(br_s1, k)) * TW'(wx_s1);
			end
			wy_s2   <= wy_s1;
			iwy_s2  <= iwy_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;

			for (int k = 0; k < 3; k++) begin
				v_s3_d[k] <= VW'(top_s2[k]) * VW'(iwy_s2) + VW'(bot_s2[k]) * VW'(wy_s2);
			end
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			last_s3 <= last_s2;

			for (int k = 0; k < 3; k++) begin
				prod_s4[k] <= PW'(((33'(v_s3_d[k]) + NORM_BIAS) >> 9)) * NORM_RECIP;
			end
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			last_s4 <= last_s3;

			res_s5.out_x      <= x_s4;
			res_s5.out_y      <= y_s4;
			res_s5.red_norm   <= prod_s4[0][46:31] - HALF_SCALE;
			res_s5.green_norm <= prod_s4[1][46:31] - HALF_SCALE;
			res_s5.blue_norm  <= prod_s4[2][46:31] - HALF_SCALE;
			res_s5.last       <= last_s4;
		end
	end

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for bilinear_resize_normalize: drives source pixels and frame
// sizes, predicts every normalized output pixel and checks them in arrival order.
// Depends on brn_pkg and the bilinear_resize_normalize RTL.
`timescale 1ns / 1ps
module testbench;
	import brn_pkg::*;

	localparam int SIDE      = 224;
	localparam int STORE_LEN = 4096;
	localparam int WDOG_MAX  = 20000;
	localparam int TAIL      = 60;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	pixel_t          in_data = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	result_t         out_data;
	logic            cfg_write = 1'b0;
	logic [1:0]      cfg_index = '0;
	logic [CFGW-1:0] cfg_data = '0;

	bilinear_resize_normalize dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state
	logic [CFGW-1:0] width_reg = SIZE_RESET;
	logic [CFGW-1:0] height_reg = SIZE_RESET;
	logic [23:0]     line_mem [STORE_LEN];
	logic [23:0]     left_pix = '0;
	logic [23:0]     above_left_pix = '0;
	int unsigned     col_pos = 0;
	int unsigned     row_pos = 0;
	int unsigned     x_lo [SIDE], x_hi [SIDE], x_wt [SIDE];
	int unsigned     y_lo [SIDE], y_hi [SIDE], y_wt [SIDE];
	result_t         pending_px [$];

	int fail_cnt = 0;
	int idle_cnt = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;

	function automatic int unsigned clamp_size(logic [CFGW-1:0] v);
		if (v < MIN_SRC_SIDE) return MIN_SRC_SIDE;
		if (v > STORE_LEN) return STORE_LEN;
		return v;
	endfunction

	// Source neighbors and weight of output index i along an axis of the given size
	task automatic map_axis(input int unsigned i, input int unsigned size,
			output int unsigned lo, output int unsigned hi, output int unsigned wt);
		longint unsigned num, q, a, top;
		num = ((longint'(2 * i + 1) * size) + SIDE) << 12;
		q = num / (2 * SIDE);
		a = q >> 12;
		top = size - 1;
		wt = q & 12'hFFF;
		hi = (a > top) ? top : a;
		lo = (a == 0) ? 0 : (((a - 1) > top) ? top : (a - 1));
	endtask

	task automatic rebuild_axes();
		for (int i = 0; i < SIDE; i++) begin
			map_axis(i, clamp_size(width_reg), x_lo[i], x_hi[i], x_wt[i]);
			map_axis(i, clamp_size(height_reg), y_lo[i], y_hi[i], y_wt[i]);
		end
	endtask

	function automatic logic [15:0] to_q14(longint unsigned v);
		longint unsigned den, n;
		den = 64'd255 << 24;
		n = ((v << 15) + (den >> 1)) / den;
		return 16'(n - 16384);
	endfunction

	// Queue every output pixel completed by this source pixel
	task automatic predict_outputs(input pixel_t p);
		logic [23:0]     pix, above, tl, tr, bl, br;
		longint unsigned one, wx, wy, tv, bv, v;
		logic [15:0]     nv [3];
		int              cnt, first;
		result_t         r;
		pix = p;
		above = line_mem[col_pos];
		one = 64'd4096;
		cnt = 0;
		first = pending_px.size();
		for (int y = 0; y < SIDE; y++) begin
			if (y_hi[y] != row_pos) continue;
			for (int x = 0; x < SIDE; x++) begin
				if (x_hi[x] != col_pos || cnt >= 64) continue;
				br = pix;
				bl = (x_lo[x] != x_hi[x]) ? left_pix : pix;
				if (y_lo[y] != y_hi[y]) begin
					tr = above;
					tl = (x_lo[x] != x_hi[x]) ? above_left_pix : above;
				end else begin
					tr = br;
					tl = bl;
				end
				wx = x_wt[x];
				wy = y_wt[y];
				for (int k = 0; k < 3; k++) begin
					tv = tl[16 - 8 * k +: 8] * (one - wx) + tr[16 - 8 * k +: 8] * wx;
					bv = bl[16 - 8 * k +: 8] * (one - wx) + br[16 - 8 * k +: 8] * wx;
					v = tv * (one - wy) + bv * wy;
					nv[k] = to_q14(v);
				end
				r.out_x = 8'(x);
				r.out_y = 8'(y);
				r.red_norm = nv[0];
				r.green_norm = nv[1];
				r.blue_norm = nv[2];
				r.last = 1'b0;
				pending_px.insert(pending_px.size(), r);
				cnt++;
			end
		end
		if (cnt > 0) pending_px[first + cnt - 1].last = 1'b1;
		above_left_pix = above;
		line_mem[col_pos] = pix;
		left_pix = pix;
		col_pos++;
		if (col_pos >= clamp_size(width_reg)) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= clamp_size(height_reg)) row_pos = 0;
		end
	endtask

	// Offer one pixel, idling first at the sender's rate, and predict on acceptance
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < snd_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = p;
		do @(posedge clk); while (in_stall);
		predict_outputs(p);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++) send_pixel(pixel_t'($urandom()));
	endtask

	// Drop valid and wait until all outputs are out and the pipeline is quiet
	task automatic drain_all();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (TAIL) @(negedge clk);
	endtask

	task automatic write_size(input logic [1:0] idx, input logic [CFGW-1:0] val);
		drain_all();
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_SRC_WIDTH) width_reg = val;
		else height_reg = val;
		col_pos = 0;
		row_pos = 0;
		rebuild_axes();
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_idling(input int s, input int r);
		snd_pct = s;
		rcv_pct = r;
	endtask

	// Channel extremes, then random pixels, at the reset size
	task automatic test_directed_extremes();
		pixel_t p;
		set_idling(0, 0);
		for (int i = 0; i < 16; i++) begin
			p.red = i[0] ? 8'hFF : 8'h00;
			p.green = i[1] ? 8'hFF : 8'h00;
			p.blue = i[2] ? 8'hFF : 8'h00;
			if (i >= 8) p = pixel_t'($urandom());
			send_pixel(p);
		end
	endtask

	// Out-of-range sizes clamp, and a write restarts the frame mid-row
	task automatic test_restart_on_write();
		set_idling(33, 33);
		write_size(REG_SRC_WIDTH, 13'd0);
		write_size(REG_SRC_HEIGHT, 13'd8191);
		send_random(30);
		write_size(REG_SRC_WIDTH, 13'd63);
		send_random(20);
		write_size(REG_SRC_HEIGHT, 13'd64);
		send_random(50);
	endtask

	// One whole smallest row, then into the next to see the row wrap
	task automatic test_row_wrap();
		set_idling(0, 0);
		write_size(REG_SRC_WIDTH, 13'd64);
		write_size(REG_SRC_HEIGHT, 13'd64);
		send_random(64 + 36);
	endtask

	// Widest row, first pixels only
	task automatic test_widest_row();
		set_idling(0, 0);
		write_size(REG_SRC_HEIGHT, 13'd64);
		write_size(REG_SRC_WIDTH, 13'd4096);
		send_random(24);
	endtask

	// Tallest frame with narrow rows
	task automatic test_tallest_frame();
		set_idling(0, 0);
		write_size(REG_SRC_WIDTH, 13'd64);
		write_size(REG_SRC_HEIGHT, 13'd4096);
		send_random(64 + 16);
	endtask

	function automatic logic [CFGW-1:0] pick_size();
		int r;
		r = $urandom_range(9);
		if (r < 7) return CFGW'($urandom_range(64, 120));
		if (r < 9) return CFGW'($urandom_range(121, 600));
		return 13'd4096;
	endfunction

	// Random frames under each idling pattern; the first phase holds the output off
	task automatic test_random_mix();
		int snd [4] = '{0, 49, 0, 33};
		int rcv [4] = '{0, 0, 49, 33};
		for (int ph = 0; ph < 4; ph++) begin
			write_size(REG_SRC_WIDTH, pick_size());
			write_size(REG_SRC_HEIGHT, pick_size());
			set_idling(snd[ph], rcv[ph]);
			if (ph == 0) hold_req = 1'b1;
			send_random(20);
			write_size(REG_SRC_WIDTH, pick_size());
			set_idling(snd[ph], rcv[ph]);
			send_random(18);
		end
	endtask

	// Receiver: random stall, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 1500;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_pct);
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_px.size() == 0) begin
				$error("unexpected output x=%0d y=%0d", out_data.out_x, out_data.out_y);
				fail_cnt++;
			end else begin
				e = pending_px.pop_front();
				if (out_data.out_x !== e.out_x) begin
					$error("out_x exp %0d got %0d", e.out_x, out_data.out_x);
					fail_cnt++;
				end
				if (out_data.out_y !== e.out_y) begin
					$error("out_y exp %0d got %0d", e.out_y, out_data.out_y);
					fail_cnt++;
				end
				if (out_data.red_norm !== e.red_norm) begin
					$error("red_norm exp %0d got %0d", e.red_norm, out_data.red_norm);
					fail_cnt++;
				end
				if (out_data.green_norm !== e.green_norm) begin
					$error("green_norm exp %0d got %0d", e.green_norm, out_data.green_norm);
					fail_cnt++;
				end
				if (out_data.blue_norm !== e.blue_norm) begin
					$error("blue_norm exp %0d got %0d", e.blue_norm, out_data.blue_norm);
					fail_cnt++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run after too long without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WDOG_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < STORE_LEN; i++) line_mem[i] = '0;
		rebuild_axes();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed_extremes();
		test_restart_on_write();
		test_row_wrap();
		test_widest_row();
		test_tallest_frame();
		test_random_mix();
		drain_all();
		if (fail_cnt == 0 && pending_px.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/brn_pkg.sv
rtl/brn_fifo.sv
rtl/brn_front.sv
rtl/brn_back.sv
rtl/bilinear_resize_normalize.sv
test/testbench.sv
